// File: rtl/imd_pkg.sv
// Shared operation codes and pipeline payload type for the multiply/divide unit.
package imd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OP_W   = 3;
	localparam int unsigned STEPS  = 32;

	localparam logic [OP_W-1:0] OP_MUL  = 3'd0;
	localparam logic [OP_W-1:0] OP_DIVU = 3'd1;
	localparam logic [OP_W-1:0] OP_REMU = 3'd2;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
	localparam logic [OP_W-1:0] OP_REM  = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              a_neg;
		logic              b_neg;
		logic [WORD_W-1:0] den;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] num;
		logic [WORD_W-1:0] prod;
	} imd_data_t;

endpackage

// File: rtl/imd_prep.sv
// Entry stage: operand magnitudes, product low word and divider setup.
module imd_prep (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [imd_pkg::OP_W-1:0]           op,
	input  logic [imd_pkg::WORD_W-1:0]         operand_a,
	input  logic [imd_pkg::WORD_W-1:0]         operand_b,
	output logic                               out_valid,
	input  logic                               out_ready,
	output imd_pkg::imd_data_t                 out_data
);

	logic               valid_s1;
	imd_pkg::imd_data_t data_s1;
	imd_pkg::imd_data_t data_d;
	logic               is_signed;

	always_comb begin
		is_signed     = (op == imd_pkg::OP_DIV) || (op == imd_pkg::OP_REM);
		data_d.op     = op;
		data_d.a_neg  = operand_a[imd_pkg::WORD_W-1];
		data_d.b_neg  = operand_b[imd_pkg::WORD_W-1];
		data_d.num    = (is_signed && operand_a[imd_pkg::WORD_W-1]) ?
		                (~operand_a + 32'd1) : operand_a;
		data_d.den    = (is_signed && operand_b[imd_pkg::WORD_W-1]) ?
		                (~operand_b + 32'd1) : operand_b;
		data_d.rem    = '0;
		data_d.prod   = operand_a * operand_b;
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_d;
		end
	end

endmodule

// File: rtl/imd_div_stage.sv
// One restoring division step: shift in a dividend bit, trial subtract, record quotient bit.
module imd_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  imd_pkg::imd_data_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output imd_pkg::imd_data_t out_data
);

	logic               valid_s1;
	imd_pkg::imd_data_t data_s1;
	imd_pkg::imd_data_t data_d;
	logic [imd_pkg::WORD_W:0] trial;
	logic [imd_pkg::WORD_W:0] diff;
	logic                     ge;

	always_comb begin
		trial       = {in_data.rem, in_data.num[imd_pkg::WORD_W-1]};
		diff        = trial - {1'b0, in_data.den};
		ge          = !diff[imd_pkg::WORD_W];
		data_d      = in_data;
		data_d.rem  = ge ? diff[imd_pkg::WORD_W-1:0] : trial[imd_pkg::WORD_W-1:0];
		data_d.num  = {in_data.num[imd_pkg::WORD_W-2:0], ge};
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_d;
		end
	end

endmodule

// File: rtl/imd_post.sv
// Result stage: select the result word, apply signs, drive the output register.
module imd_post (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  imd_pkg::imd_data_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [imd_pkg::WORD_W-1:0] result
);

	logic                       valid_q;
	logic [imd_pkg::WORD_W-1:0] result_q;
	logic [imd_pkg::WORD_W-1:0] result_d;

	always_comb begin
		case (in_data.op)
			imd_pkg::OP_MUL:  result_d = in_data.prod;
			imd_pkg::OP_DIVU: result_d = in_data.num;
			imd_pkg::OP_REMU: result_d = in_data.rem;
			imd_pkg::OP_DIV:  result_d = (in_data.a_neg ^ in_data.b_neg) ?
			                             (~in_data.num + 32'd1) : in_data.num;
			imd_pkg::OP_REM:  result_d = in_data.a_neg ?
			                             (~in_data.rem + 32'd1) : in_data.rem;
			default:          result_d = '0;
		endcase
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= result_d;
		end
	end

endmodule

// File: rtl/integer_multiply_divide_32.sv
// Top level of the pipelined 32-bit integer multiply/divide unit.
// Accepts one transaction per clock when the output side keeps up and returns one result
// word per transaction, in order, through one entry stage (magnitudes and the 32x32 product
// low word), 32 stages of one restoring division bit each, and the output register. Each
// stage holds its own valid bit and moves on whenever the stage after it is empty or moving,
// so empty slots close up under back-pressure and a full pipeline holds 34 transactions.
module integer_multiply_divide_32 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [imd_pkg::OP_W-1:0]   op,
	input  logic [imd_pkg::WORD_W-1:0] operand_a,
	input  logic [imd_pkg::WORD_W-1:0] operand_b,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [imd_pkg::WORD_W-1:0] result
);

	localparam int unsigned NSTG = imd_pkg::STEPS + 1;

	logic               vld  [0:NSTG-1];
	logic               rdy  [0:NSTG];
	imd_pkg::imd_data_t dat  [0:NSTG-1];

	imd_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (rdy[0]),
		.op        (op),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (vld[0]),
		.out_ready (rdy[1]),
		.out_data  (dat[0])
	);

	for (genvar k = 1; k < NSTG; k++) begin : g_div
		imd_div_stage u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[k-1]),
			.in_ready  (rdy[k]),
			.in_data   (dat[k-1]),
			.out_valid (vld[k]),
			.out_ready (rdy[k+1]),
			.out_data  (dat[k])
		);
	end

	imd_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[NSTG-1]),
		.in_ready  (rdy[NSTG]),
		.in_data   (dat[NSTG-1]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign in_ready = rdy[0];

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld[0])
		else $error("entry stage refused a transaction while empty");

	a_entry_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] && !rdy[1] |=> vld[0] && $stable(dat[0]))
		else $error("entry stage lost or changed a stalled transaction");

	a_last_step_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld[NSTG-1] && !rdy[NSTG] |=> vld[NSTG-1] && $stable(dat[NSTG-1]))
		else $error("last division stage lost or changed a stalled transaction");

	a_out_fed: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !vld[NSTG-1] |=> !out_valid)
		else $error("output valid rose without a transaction from the divider");

endmodule
